FILE: design/mrv_pkg.sv
// ============================================================================
// mrv_pkg: shared types, constants and functions for the Modbus response validator
// Holds the frame limits, the status codes and the CRC-16 byte update.
// ============================================================================
package mrv_pkg;

    localparam int FRAME_CAPACITY = 256;
    localparam int CNT_W          = $clog2(FRAME_CAPACITY + 1);
    localparam int LEN_W          = 9;

    localparam logic [15:0]      CRC_PRESET    = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY      = 16'hA001;
    localparam logic [7:0]       EXCEPTION_BIT = 8'h80;
    localparam logic [CNT_W-1:0] MIN_FRAME     = CNT_W'(6);
    localparam logic [CNT_W-1:0] CAP_COUNT     = CNT_W'(FRAME_CAPACITY);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_SHORT     = 3'd2,
        ST_BAD_CRC   = 3'd3,
        ST_EXCEPTION = 3'd4,
        ST_BAD_FUNC  = 3'd5
    } status_t;

    // Advance the reflected CRC-16 by one byte, one bit per step.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic func_supported(input logic [7:0] f);
        return f inside {[8'd1:8'd6], 8'd15, 8'd16};
    endfunction

endpackage

FILE: design/modbus_response_validator.sv
// ============================================================================
// modbus_response_validator: Modbus RTU response frame checker
// Runs CRC-16 over each received frame, holds back the trailing CRC bytes,
// and issues one status per frame with function code, length and counters.
// ============================================================================
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------
//  item     | item_valid / item_ready     | rx_byte, end_of_frame
//  result   | result_valid / result_ready | status, function_code, frame_length,
//           |                             | error_total, frames_total
//
// One byte a cycle sustained while no end-of-frame byte waits on a full result
// register. A byte lands in the input register and is then folded into the
// frame state, where one unrolled 8-bit CRC step takes in the byte two places
// before it; an end-of-frame byte loads the status into the result register
// as it leaves the input register. Reset clears the frame state, both counters
// and both valid flags. A stalled result holds only end-of-frame bytes; other
// bytes keep flowing into the frame state while a result waits.
//
module modbus_response_validator
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic [7:0]               rx_byte,
    input  logic                     end_of_frame,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [2:0]               status,
    output logic [7:0]               function_code,
    output logic [mrv_pkg::LEN_W-1:0] frame_length,
    output logic [15:0]              error_total,
    output logic [15:0]              frames_total
);
    import mrv_pkg::*;

    // Input register
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_eof_reg;

    // Frame state
    logic [15:0]      crc_reg,     crc_next;
    logic [7:0]       older_reg,   older_next;
    logic [7:0]       newer_reg,   newer_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [7:0]       func_reg,    func_next;
    logic             ovf_reg,     ovf_next;
    logic [15:0]      err_cnt_reg, err_cnt_next;
    logic [15:0]      frm_cnt_reg, frm_cnt_next;

    // Result register
    logic             out_valid_reg;
    status_t          out_status_reg, out_status_next;
    logic [7:0]       out_func_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic [15:0]      out_err_reg;
    logic [15:0]      out_frm_reg;

    logic             out_free;
    logic             fire;
    logic             emit;
    logic [15:0]      rx_crc;
    logic [15:0]      crc_upd;
    logic [CNT_W-1:0] count_upd;
    logic             ovf_upd;
    logic [7:0]       older_upd;
    logic [7:0]       newer_upd;
    logic [7:0]       func_upd;

    // The result slot is free when empty or being drained this cycle.
    assign out_free   = !out_valid_reg || result_ready;
    // A plain byte never needs the result slot; an end byte waits for it.
    assign fire       = in_valid_reg && (!in_eof_reg || out_free);
    assign emit       = fire && in_eof_reg;
    assign item_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_byte_reg <= rx_byte;
            in_eof_reg  <= end_of_frame;
        end
    end

    // Fold the byte into the frame; a byte past capacity is dropped.
    always_comb
    begin
        crc_upd   = crc_reg;
        older_upd = older_reg;
        newer_upd = newer_reg;
        func_upd  = func_reg;
        count_upd = count_reg;
        ovf_upd   = ovf_reg;
        if (count_reg == CAP_COUNT)
        begin
            ovf_upd = 1'b1;
        end
        else
        begin
            if (count_reg >= CNT_W'(2))
            begin
                crc_upd = crc_feed(crc_reg, older_reg);
            end
            older_upd = newer_reg;
            newer_upd = in_byte_reg;
            if (count_reg == CNT_W'(1))
            begin
                func_upd = in_byte_reg;
            end
            count_upd = count_reg + CNT_W'(1);
        end
    end

    // CRC travels low byte first.
    assign rx_crc = {newer_upd, older_upd};

    // Check in priority order.
    always_comb
    begin
        if (ovf_upd)
        begin
            out_status_next = ST_OVERFLOW;
        end
        else if (count_upd < MIN_FRAME)
        begin
            out_status_next = ST_SHORT;
        end
        else if (crc_upd != rx_crc)
        begin
            out_status_next = ST_BAD_CRC;
        end
        else if ((func_upd & EXCEPTION_BIT) != 8'h00)
        begin
            out_status_next = ST_EXCEPTION;
        end
        else if (!func_supported(func_upd))
        begin
            out_status_next = ST_BAD_FUNC;
        end
        else
        begin
            out_status_next = ST_OK;
        end
    end

    // Next frame state and counters: hold unless a byte fires; an end byte clears the frame.
    always_comb
    begin
        crc_next     = crc_reg;
        older_next   = older_reg;
        newer_next   = newer_reg;
        count_next   = count_reg;
        func_next    = func_reg;
        ovf_next     = ovf_reg;
        err_cnt_next = err_cnt_reg;
        frm_cnt_next = frm_cnt_reg;
        if (fire)
        begin
            if (in_eof_reg)
            begin
                crc_next   = CRC_PRESET;
                older_next = 8'h00;
                newer_next = 8'h00;
                count_next = '0;
                func_next  = 8'h00;
                ovf_next   = 1'b0;
                if (!ovf_upd)
                begin
                    frm_cnt_next = frm_cnt_reg + 16'd1;
                    if (out_status_next != ST_OK)
                    begin
                        err_cnt_next = err_cnt_reg + 16'd1;
                    end
                end
            end
            else
            begin
                crc_next   = crc_upd;
                older_next = older_upd;
                newer_next = newer_upd;
                count_next = count_upd;
                func_next  = func_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= CRC_PRESET;
            older_reg   <= 8'h00;
            newer_reg   <= 8'h00;
            count_reg   <= '0;
            func_reg    <= 8'h00;
            ovf_reg     <= 1'b0;
            err_cnt_reg <= 16'd0;
            frm_cnt_reg <= 16'd0;
        end
        else
        begin
            crc_reg     <= crc_next;
            older_reg   <= older_next;
            newer_reg   <= newer_next;
            count_reg   <= count_next;
            func_reg    <= func_next;
            ovf_reg     <= ovf_next;
            err_cnt_reg <= err_cnt_next;
            frm_cnt_reg <= frm_cnt_next;
        end
    end

    // Result register: load on an end byte, drop valid once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= out_status_next;
            out_func_reg   <= func_upd;
            out_len_reg    <= count_upd[LEN_W-1:0];
            out_err_reg    <= err_cnt_next;
            out_frm_reg    <= frm_cnt_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign status        = out_status_reg;
    assign function_code = out_func_reg;
    assign frame_length  = out_len_reg;
    assign error_total   = out_err_reg;
    assign frames_total  = out_frm_reg;

endmodule
